>>> design/lprl_pkg.sv
`default_nettype none
package lprl_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned IDX_OUT_W   = 6;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOROUTE = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [31:0] mask;
    logic [15:0] gateway_id;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [15:0]          gateway_out;
    logic [IDX_OUT_W-1:0] match_index;
    logic [31:0]          best_mask;
  } out_t;

  // Lookup token passed from cell to cell, carrying the best match so far.
  typedef struct packed {
    logic                 valid;
    logic [31:0]          addr;
    logic                 found;
    logic [31:0]          best_mask;
    logic [15:0]          best_gw;
    logic [IDX_OUT_W-1:0] best_idx;
  } probe_t;

  // Write strobe shared by all cells; the cell whose index equals cnt takes it.
  typedef struct packed {
    logic        en;
    logic [31:0] network;
    logic [31:0] mask;
    logic [15:0] gw;
  } wr_t;

endpackage
`default_nettype wire

>>> design/lprl_cell.sv
`default_nettype none
module lprl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CntW  = 7
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire  [CntW-1:0]       cnt_i,
  input  lprl_pkg::wr_t         wr_i,
  input  lprl_pkg::probe_t      probe_i,
  output lprl_pkg::probe_t      probe_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(INDEX);
  localparam logic [lprl_pkg::IDX_OUT_W-1:0] MyIdxOut = lprl_pkg::IDX_OUT_W'(INDEX);

  logic [31:0] network_q;
  logic [31:0] mask_q;
  logic [15:0] gw_q;

  logic             active;
  logic             hit;
  lprl_pkg::probe_t probe_d;
  lprl_pkg::probe_t probe_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (cnt_i == MyIdx)) begin
      network_q <= wr_i.network;
      mask_q    <= wr_i.mask;
      gw_q      <= wr_i.gw;
    end
  end

  assign active = (MyIdx < cnt_i);
  // later entry wins on equal masks
  assign hit = active && ((probe_i.addr & mask_q) == network_q) &&
               (!probe_i.found || (mask_q >= probe_i.best_mask));

  always_comb begin
    probe_d = probe_i;
    if (hit) begin
      probe_d.found     = 1'b1;
      probe_d.best_mask = mask_q;
      probe_d.best_gw   = gw_q;
      probe_d.best_idx  = MyIdxOut;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule
`default_nettype wire

>>> design/longest_prefix_route_lookup.sv
`default_nettype none
// Add, clear and unused codes: result word valid in the cycle after acceptance.
// Lookup: the token walks the cell row one cell per cycle, and the result
// word is registered after the last cell; one item is in flight at a time.
// Throughput: 1 word per cycle for add/clear while out_ready_i is high.
// Reset empties the table (entry count zero) and drops any pending word.
module longest_prefix_route_lookup #(
  parameter int unsigned ENTRIES = lprl_pkg::ENTRIES_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  lprl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output lprl_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] Full = CntW'(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  lprl_pkg::out_t      out_q, out_d;
  logic                in_acc;
  logic                is_add, is_lookup, is_clear;
  logic                full;
  logic [CntW+5:0]     cnt_ext;
  lprl_pkg::wr_t       wr;
  lprl_pkg::probe_t    probes [ENTRIES+1];

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_add     = (in_data_i.action == lprl_pkg::ACT_ADD);
  assign is_lookup  = (in_data_i.action == lprl_pkg::ACT_LOOKUP);
  assign is_clear   = (in_data_i.action == lprl_pkg::ACT_CLEAR);
  assign full       = (cnt_q == Full);
  assign cnt_ext    = {6'b0, cnt_q};

  assign wr.en      = in_acc && is_add && !full;
  assign wr.network = in_data_i.address & in_data_i.mask;
  assign wr.mask    = in_data_i.mask;
  assign wr.gw      = in_data_i.gateway_id;

  always_comb begin
    probes[0]           = '0;
    probes[0].valid     = in_acc && is_lookup;
    probes[0].addr      = in_data_i.address;
  end

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    lprl_cell #(
      .INDEX(k),
      .CntW (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cnt_i  (cnt_q),
      .wr_i   (wr),
      .probe_i(probes[k]),
      .probe_o(probes[k+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_lookup) begin
            state_d = ST_SCAN;
          end else begin
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.status = lprl_pkg::STAT_OK;
            if (is_add) begin
              if (full) begin
                out_d.status = lprl_pkg::STAT_FULL;
              end else begin
                out_d.gateway_out = in_data_i.gateway_id;
                out_d.match_index = cnt_ext[5:0];
                out_d.best_mask   = in_data_i.mask;
                cnt_d             = cnt_q + 1'b1;
              end
            end else if (is_clear) begin
              cnt_d = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (probes[ENTRIES].valid) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_d       = '0;
          if (probes[ENTRIES].found) begin
            out_d.status      = lprl_pkg::STAT_OK;
            out_d.gateway_out = probes[ENTRIES].best_gw;
            out_d.match_index = probes[ENTRIES].best_idx;
            out_d.best_mask   = probes[ENTRIES].best_mask;
          end else begin
            out_d.status = lprl_pkg::STAT_NOROUTE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("entry count beyond table size");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

  a_lookup_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_lookup) |=> (state_q == ST_SCAN))
    else $error("lookup did not start a scan");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probes[ENTRIES].valid |-> (state_q == ST_SCAN && !out_valid_q))
    else $error("scan token arrived outside a scan or onto a full output");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(cnt_q))
    else $error("table changed during a scan");

endmodule
`default_nettype wire

>>> tb/sv/route_lookup_checker.sv
module route_lookup_checker
  import lprl_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  wire  in_ready_i,
  input  in_t  in_data_i,
  input  wire  out_valid_i,
  input  wire  out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   words_pending_o
);

  logic [31:0] tbl_network [ENTRIES];
  logic [31:0] tbl_mask    [ENTRIES];
  logic [15:0] tbl_gateway [ENTRIES];
  int          tbl_count;
  out_t        route_results_q [$];

  // Applies one request word to the shadow table and returns the result word.
  function automatic out_t predict_route_result(in_t w);
    out_t r;
    logic found;
    r = '0;
    r.status = STAT_OK;
    found = 1'b0;
    case (w.action)
      ACT_ADD: begin
        if (tbl_count >= ENTRIES) begin
          r.status = STAT_FULL;
        end else begin
          tbl_network[tbl_count] = w.address & w.mask;
          tbl_mask[tbl_count]    = w.mask;
          tbl_gateway[tbl_count] = w.gateway_id;
          r.gateway_out = w.gateway_id;
          r.match_index = IDX_OUT_W'(tbl_count);
          r.best_mask   = w.mask;
          tbl_count++;
        end
      end
      ACT_LOOKUP: begin
        // >= so that a later entry takes a tie
        for (int k = 0; k < tbl_count; k++) begin
          if ((w.address & tbl_mask[k]) == tbl_network[k] &&
              (!found || tbl_mask[k] >= r.best_mask)) begin
            found         = 1'b1;
            r.best_mask   = tbl_mask[k];
            r.gateway_out = tbl_gateway[k];
            r.match_index = IDX_OUT_W'(k);
          end
        end
        if (!found) r.status = STAT_NOROUTE;
      end
      ACT_CLEAR: begin
        tbl_count = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got_req;
    if (!rst_ni) begin
      route_results_q.delete();
      tbl_count = 0;
      words_pending_o <= 0;
    end else begin
      // retire first: a word leaving now belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        if (route_results_q.size() == 0) begin
          $display("%0t: result word %h with nothing expected", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = route_results_q.pop_front();
          if (want.status !== out_data_i.status) begin
            $display("%0t: status expected %0d, actual %0d",
                     $time, want.status, out_data_i.status);
            fail_count_o++;
          end
          if (want.gateway_out !== out_data_i.gateway_out) begin
            $display("%0t: gateway_out expected %h, actual %h",
                     $time, want.gateway_out, out_data_i.gateway_out);
            fail_count_o++;
          end
          if (want.match_index !== out_data_i.match_index) begin
            $display("%0t: match_index expected %0d, actual %0d",
                     $time, want.match_index, out_data_i.match_index);
            fail_count_o++;
          end
          if (want.best_mask !== out_data_i.best_mask) begin
            $display("%0t: best_mask expected %h, actual %h",
                     $time, want.best_mask, out_data_i.best_mask);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        got_req = predict_route_result(in_data_i);
        route_results_q.insert(route_results_q.size(), got_req);
      end
      words_pending_o <= route_results_q.size();
    end
  end

endmodule

>>> tb/sv/longest_prefix_route_lookup_tb.sv
module longest_prefix_route_lookup_tb;
  import lprl_pkg::*;

  localparam int unsigned ENTRIES        = ENTRIES_DEF;
  localparam int          RANDOM_ITEMS   = 1650;
  localparam int          TIMEOUT_CYCLES = 1_000_000;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   words_pending;
  int   idle_pct  = 32;

  // addresses already added; lookups and new routes are aimed near them
  logic [31:0] known_addrs [$];

  always #10 clk = ~clk;

  longest_prefix_route_lookup #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  route_lookup_checker #(
    .ENTRIES(ENTRIES)
  ) route_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .words_pending_o(words_pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  task automatic send_item(input logic [1:0] act, input logic [31:0] addr,
                           input logic [31:0] msk, input logic [15:0] gw);
    in_t w;
    w.action     = act;
    w.address    = addr;
    w.mask       = msk;
    w.gateway_id = gw;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_ADD) known_addrs.insert(known_addrs.size(), addr);
    if (act == ACT_CLEAR) known_addrs.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  function automatic logic [31:0] random_mask();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(0, 32);
    if (pick < 5) return '0;
    if (pick < 12) return '1;
    if (pick < 25) return $urandom();
    return (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
  endfunction

  function automatic logic [31:0] near_known_addr();
    logic [31:0] base;
    if (known_addrs.size() == 0 || $urandom_range(0, 99) < 25) return $urandom();
    base = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    return base ^ ($urandom() >> $urandom_range(0, 32));
  endfunction

  initial begin
    int sent;
    int phase;
    int n_add;
    int n_look;
    int pick;
    logic [1:0] act;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ACT_LOOKUP, 32'h0A00_0001, '0, '0);
    send_item(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);  // default route
    send_item(ACT_ADD, 32'h0A00_0000, 32'hFF00_0000, 16'h0001);
    send_item(ACT_ADD, 32'h0A01_FFFF, 32'hFFFF_0000, 16'h0002);  // host bits dropped
    send_item(ACT_ADD, 32'h0A01_0000, 32'hFFFF_0000, 16'h0003);  // same mask, later wins
    send_item(ACT_ADD, 32'hC0A8_0101, 32'hFFFF_FFFF, 16'h8000);
    send_item(ACT_ADD, 32'hF0F0_F0F0, 32'hF0F0_F0F0, 16'h1234);  // non-contiguous
    send_item(ACT_LOOKUP, 32'h0A01_0203, '0, '0);
    send_item(ACT_LOOKUP, 32'h0A7F_0000, '0, '0);
    send_item(ACT_LOOKUP, 32'hC0A8_0101, '1, '1);
    send_item(ACT_LOOKUP, 32'hC0A8_0100, '0, '0);
    send_item(ACT_LOOKUP, 32'h0000_0000, '0, '0);
    send_item(ACT_LOOKUP, 32'hF5F5_F5F5, '0, '0);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_item(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_LOOKUP, 32'h0A01_0203, '0, '0);
    send_item(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_item(ACT_ADD, 32'h1234_5678, 32'hAAAA_AAAA, 16'h5555);
    send_item(ACT_LOOKUP, 32'h1234_5678, '0, '0);
    send_item(ACT_LOOKUP, 32'h0000_5678, '0, '0);
    send_item(ACT_CLEAR, '0, '0, '0);

    // each phase: optional clear, a burst of adds (sometimes past full),
    // then lookups with the odd add and some noise mixed in
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = (phase >= 6 && phase < 10) ? 0 : 32;
      if (phase == 0 || $urandom_range(0, 99) < 40) begin
        send_item(ACT_CLEAR, $urandom(), $urandom(), 16'($urandom()));
        sent++;
      end
      n_add  = (phase == 0 || $urandom_range(0, 99) < 20) ? $urandom_range(60, 72)
                                                          : $urandom_range(1, 16);
      n_look = $urandom_range(4, 24);
      for (int i = 0; i < n_add + n_look; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6 && phase != 0) begin
          act = 2'($urandom_range(0, 3));
          send_item(act, $urandom(), $urandom(), 16'($urandom()));
          if (act != ACT_UNUSED) sent++;
        end else if (i < n_add || pick < 16) begin
          send_item(ACT_ADD, (pick < 50) ? near_known_addr() : $urandom(),
                    random_mask(), 16'($urandom()));
          sent++;
        end else begin
          send_item(ACT_LOOKUP, near_known_addr(), $urandom(), 16'($urandom()));
          sent++;
        end
      end
      if (phase % 5 == 3) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (ENTRIES + 10) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
design/lprl_pkg.sv
design/lprl_cell.sv
design/longest_prefix_route_lookup.sv
tb/sv/route_lookup_checker.sv
tb/sv/longest_prefix_route_lookup_tb.sv
